@@ design/chs_pkg.sv @@
package chs_pkg;

  localparam int unsigned MaxBuckets   = 256;
  localparam int unsigned PoolNodes    = 1024;
  localparam int unsigned KeyWidth     = 32;
  localparam int unsigned MinBuckets   = 5;
  localparam int unsigned ResetBuckets = 7;

  localparam int unsigned BktW  = $clog2(MaxBuckets);
  localparam int unsigned PtrW  = $clog2(PoolNodes) + 1;
  localparam int unsigned IdxW  = $clog2(PoolNodes);
  localparam int unsigned CfgW  = 9;
  localparam int unsigned StepW = $clog2(PoolNodes + 1);
  localparam int unsigned ModW  = 10;

  localparam logic [PtrW-1:0] Nil = PtrW'(PoolNodes);

  typedef enum logic [1:0] {
    OpFind   = 2'd0,
    OpInsert = 2'd1,
    OpDelete = 2'd2,
    OpSpare  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StAbsent  = 2'd1,
    StPresent = 2'd2,
    StFull    = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    SIdle,
    SMod,
    SHead,
    SWalk,
    SCmp,
    SAlloc,
    SFreeRd,
    SInsWr,
    SDelRd,
    SDelWr,
    SDone
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic mod_step;
    logic head_rd;
    logic node_rd;
    logic advance;
    logic free_rd;
    logic alloc;
    logic ins_wr;
    logic del_rd;
    logic del_wr;
    logic done;
    logic [1:0] status;
  } ctrl_t;

  // Datapath to controller.
  typedef struct packed {
    logic mod_done;
    logic cur_nil;
    logic key_hit;
    logic free_avail;
    logic fresh_avail;
    op_e  op;
  } stat_t;

endpackage

@@ design/chs_ctrl.sv @@
module chs_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  chs_pkg::stat_t stat_i,
  output chs_pkg::ctrl_t ctrl_o,
  output logic           busy_o
);

  chs_pkg::state_e state_q, state_d;
  logic [1:0] status_q, status_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= chs_pkg::SIdle;
      status_q <= chs_pkg::StOk;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    status_d = status_q;
    unique case (state_q)
      chs_pkg::SIdle:  if (start_i) state_d = chs_pkg::SMod;
      chs_pkg::SMod:   if (stat_i.mod_done) state_d = chs_pkg::SHead;
      chs_pkg::SHead:  state_d = chs_pkg::SWalk;
      chs_pkg::SWalk: begin
        if (stat_i.cur_nil) begin
          if (stat_i.op == chs_pkg::OpInsert) begin
            if (stat_i.free_avail) state_d = chs_pkg::SFreeRd;
            else if (stat_i.fresh_avail) state_d = chs_pkg::SAlloc;
            else begin
              status_d = chs_pkg::StFull;
              state_d  = chs_pkg::SDone;
            end
          end else begin
            status_d = chs_pkg::StAbsent;
            state_d  = chs_pkg::SDone;
          end
        end else begin
          state_d = chs_pkg::SCmp;
        end
      end
      chs_pkg::SCmp: begin
        if (stat_i.key_hit) begin
          if (stat_i.op == chs_pkg::OpInsert) begin
            status_d = chs_pkg::StPresent;
            state_d  = chs_pkg::SDone;
          end else if (stat_i.op == chs_pkg::OpDelete) begin
            state_d = chs_pkg::SDelRd;
          end else begin
            status_d = chs_pkg::StOk;
            state_d  = chs_pkg::SDone;
          end
        end else begin
          state_d = chs_pkg::SWalk;
        end
      end
      chs_pkg::SFreeRd: state_d = chs_pkg::SAlloc;
      chs_pkg::SAlloc:  state_d = chs_pkg::SInsWr;
      chs_pkg::SInsWr: begin
        status_d = chs_pkg::StOk;
        state_d  = chs_pkg::SDone;
      end
      chs_pkg::SDelRd: state_d = chs_pkg::SDelWr;
      chs_pkg::SDelWr: begin
        status_d = chs_pkg::StOk;
        state_d  = chs_pkg::SDone;
      end
      chs_pkg::SDone:  state_d = chs_pkg::SIdle;
      default:         state_d = chs_pkg::SIdle;
    endcase
  end

  always_comb begin
    ctrl_o        = '0;
    ctrl_o.status = status_q;
    busy_o        = (state_q != chs_pkg::SIdle);
    unique case (state_q)
      chs_pkg::SIdle:   ctrl_o.load     = start_i;
      chs_pkg::SMod:    ctrl_o.mod_step = 1'b1;
      chs_pkg::SHead:   ctrl_o.head_rd  = 1'b1;
      chs_pkg::SWalk:   ctrl_o.node_rd  = !stat_i.cur_nil;
      chs_pkg::SCmp:    ctrl_o.advance  = !stat_i.key_hit;
      chs_pkg::SFreeRd: ctrl_o.free_rd  = 1'b1;
      chs_pkg::SAlloc:  ctrl_o.alloc    = 1'b1;
      chs_pkg::SInsWr:  ctrl_o.ins_wr   = 1'b1;
      chs_pkg::SDelRd:  ctrl_o.del_rd   = 1'b1;
      chs_pkg::SDelWr:  ctrl_o.del_wr   = 1'b1;
      chs_pkg::SDone:   ctrl_o.done     = 1'b1;
      default:          ctrl_o          = '0;
    endcase
  end

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.done |=> state_q == chs_pkg::SIdle)
    else $error("done not followed by idle");
  a_load_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.load |=> state_q == chs_pkg::SMod)
    else $error("accepted start did not begin modulo");
  a_busy_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> !ctrl_o.load)
    else $error("load while busy");

endmodule

@@ design/chs_datapath.sv @@
module chs_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [chs_pkg::CfgW-1:0]        cfg_bucket_count_i,
  input  logic [1:0]                      opcode_i,
  input  logic [chs_pkg::KeyWidth-1:0]    key_i,
  input  chs_pkg::ctrl_t                  ctrl_i,
  output chs_pkg::stat_t                  stat_o
);

  localparam int unsigned KeyW = chs_pkg::KeyWidth;
  localparam int unsigned PtrW = chs_pkg::PtrW;
  localparam int unsigned IdxW = chs_pkg::IdxW;
  localparam int unsigned BktW = chs_pkg::BktW;
  localparam int unsigned CntW = $clog2(KeyW + 1);

  logic [KeyW-1:0] node_keys  [chs_pkg::PoolNodes];
  logic [PtrW-1:0] node_links [chs_pkg::PoolNodes];
  logic [PtrW-1:0] heads      [chs_pkg::MaxBuckets];
  logic [chs_pkg::MaxBuckets-1:0] head_vld_q;

  chs_pkg::op_e op_q;
  logic [KeyW-1:0] key_q;
  logic [KeyW-1:0] rem_q, rem_d;
  logic [KeyW-1:0] quo_q;
  logic [CntW-1:0] cnt_q;
  logic [chs_pkg::ModW-1:0] div_q;
  logic [PtrW-1:0] cur_q, prev_q, new_q, free_q;
  logic [PtrW-1:0] head_rd_q, link_rd_q;
  logic [KeyW-1:0] key_rd_q;
  logic [PtrW-1:0] hit_link_q;
  logic [chs_pkg::StepW-1:0] steps_q;
  logic [PtrW-1:0] used_q;
  logic [BktW-1:0] bkt;
  logic [chs_pkg::ModW-1:0] nclamp;
  logic            walked_q;

  // Restoring division of the key by the clamped bucket count, one bit a cycle.
  always_comb begin
    if (cfg_bucket_count_i < chs_pkg::CfgW'(chs_pkg::MinBuckets))
      nclamp = chs_pkg::ModW'(chs_pkg::MinBuckets);
    else if (cfg_bucket_count_i > chs_pkg::CfgW'(chs_pkg::MaxBuckets))
      nclamp = chs_pkg::ModW'(chs_pkg::MaxBuckets);
    else
      nclamp = chs_pkg::ModW'(cfg_bucket_count_i);
  end

  logic [KeyW:0] trial;
  assign trial = {rem_q, quo_q[KeyW-1]} - (KeyW+1)'(div_q);
  always_comb begin
    if (!trial[KeyW]) rem_d = trial[KeyW-1:0];
    else rem_d = {rem_q[KeyW-2:0], quo_q[KeyW-1]};
  end
  assign bkt = rem_q[BktW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_vld_q <= '0;
      free_q     <= chs_pkg::Nil;
      used_q     <= '0;
      cnt_q      <= '0;
    end else begin
      if (ctrl_i.load) begin
        cnt_q <= CntW'(KeyW);
      end else if (ctrl_i.mod_step && cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
      end
      // The link of the reused node was read in the cycle before.
      if (ctrl_i.alloc && walked_q) free_q <= link_rd_q;
      if (ctrl_i.alloc && !walked_q) used_q <= used_q + 1'b1;
      if (ctrl_i.ins_wr) head_vld_q[bkt] <= 1'b1;
      if (ctrl_i.del_wr && prev_q == chs_pkg::Nil) head_vld_q[bkt] <= 1'b1;
      if (ctrl_i.del_wr) free_q <= cur_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      op_q  <= chs_pkg::op_e'(opcode_i);
      key_q <= key_i;
      quo_q <= key_i;
      rem_q <= '0;
      div_q <= nclamp;
    end else if (ctrl_i.mod_step && cnt_q != '0) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[KeyW-2:0], 1'b0};
    end
    if (ctrl_i.head_rd) begin
      head_rd_q <= heads[bkt];
      cur_q     <= head_vld_q[bkt] ? heads[bkt] : chs_pkg::Nil;
      prev_q    <= chs_pkg::Nil;
      steps_q   <= '0;
    end
    if (ctrl_i.node_rd) begin
      key_rd_q  <= node_keys[cur_q[IdxW-1:0]];
      link_rd_q <= node_links[cur_q[IdxW-1:0]];
    end
    if (ctrl_i.advance) begin
      prev_q  <= cur_q;
      cur_q   <= (steps_q == chs_pkg::StepW'(chs_pkg::PoolNodes - 1)) ? chs_pkg::Nil
                 : link_rd_q;
      steps_q <= steps_q + 1'b1;
    end
    if (ctrl_i.free_rd) begin
      link_rd_q <= node_links[free_q[IdxW-1:0]];
      new_q     <= free_q;
      walked_q  <= 1'b1;
    end else if (ctrl_i.head_rd) begin
      walked_q  <= 1'b0;
      new_q     <= used_q;
    end
    if (ctrl_i.ins_wr) begin
      node_keys[new_q[IdxW-1:0]]  <= key_q;
      node_links[new_q[IdxW-1:0]] <= head_vld_q[bkt] ? head_rd_q : chs_pkg::Nil;
      heads[bkt]                  <= new_q;
    end
    // The deleted node is linked to the head of the free list before its chain is relinked.
    if (ctrl_i.del_rd) begin
      hit_link_q                  <= link_rd_q;
      node_links[cur_q[IdxW-1:0]] <= free_q;
    end
    if (ctrl_i.del_wr) begin
      if (prev_q == chs_pkg::Nil) heads[bkt] <= hit_link_q;
      else node_links[prev_q[IdxW-1:0]] <= hit_link_q;
    end
  end

  assign stat_o.mod_done    = (cnt_q == '0) && !ctrl_i.load;
  assign stat_o.cur_nil     = (cur_q == chs_pkg::Nil);
  assign stat_o.key_hit     = (key_rd_q == key_q);
  assign stat_o.free_avail  = (free_q != chs_pkg::Nil);
  assign stat_o.fresh_avail = (used_q < PtrW'(chs_pkg::PoolNodes));
  assign stat_o.op          = op_q;

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= PtrW'(chs_pkg::PoolNodes))
    else $error("fresh node count overran the pool");
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.head_rd) |-> rem_q < KeyW'(div_q))
    else $error("remainder not below the divisor");
  a_free_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.del_wr |=> free_q != chs_pkg::Nil)
    else $error("free list empty right after a delete");

endmodule

@@ design/chained_hash_set.sv @@
// Hash set of 32-bit keys with separate chaining over a 1024-node pool and
// up to 256 buckets. Raise start while busy is low to issue a find (0),
// insert (1) or delete (2) on key_i; opcode 3 acts as a find. Exactly one
// status transaction follows: done_o is high for one cycle with status_o
// (0 found or done, 1 absent, 2 already present, 3 pool full). The receiver
// cannot stall, so done_o must be sampled in that cycle. A request runs the
// bit-serial key modulo, a head read, then a node read and a key compare for
// each chain node visited, then allocation or unlinking where needed, and
// ends in the status cycle. The bucket count must be written through
// cfg_we_i and cfg_wdata_i only while busy is low; the block itself does
// not enforce this. Values outside 5..256 are clamped. Bucket heads are
// valid after reset without a clearing pass.
module chained_hash_set (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   opcode_i,
  input  logic [chs_pkg::KeyWidth-1:0] key_i,
  output logic                         done_o,
  output logic [1:0]                   status_o,
  input  logic                         cfg_we_i,
  input  logic [chs_pkg::CfgW-1:0]     cfg_wdata_i
);

  logic [chs_pkg::CfgW-1:0] bucket_count_q;
  chs_pkg::ctrl_t ctrl;
  chs_pkg::stat_t stat;

  // The configuration register for the bucket count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bucket_count_q <= chs_pkg::CfgW'(chs_pkg::ResetBuckets);
    end else if (cfg_we_i) begin
      bucket_count_q <= cfg_wdata_i;
    end
  end

  chs_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .stat_i (stat),
    .ctrl_o (ctrl),
    .busy_o (busy)
  );

  chs_datapath u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_bucket_count_i(bucket_count_q),
    .opcode_i          (opcode_i),
    .key_i             (key_i),
    .ctrl_i            (ctrl),
    .stat_o            (stat)
  );

  assign done_o   = ctrl.done;
  assign status_o = ctrl.status;

endmodule

@@ bench/chained_hash_set_tb.sv @@
module chained_hash_set_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Clock, reset and the block's ports. Every input starts at a known value.
  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         start = 1'b0;
  logic                         busy;
  logic [1:0]                   opcode_i = '0;
  logic [chs_pkg::KeyWidth-1:0] key_i = '0;
  logic                         done_o;
  logic [1:0]                   status_o;
  logic                         cfg_we_i = 1'b0;
  logic [chs_pkg::CfgW-1:0]     cfg_wdata_i = '0;

  chained_hash_set dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .opcode_i   (opcode_i),
    .key_i      (key_i),
    .done_o     (done_o),
    .status_o   (status_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the table: bucket heads, node pool, free list and the
  // count of fresh nodes handed out so far. The null pointer is PoolNodes.
  int unsigned                  shadow_buckets;
  int unsigned                  shadow_heads [chs_pkg::MaxBuckets];
  logic [chs_pkg::KeyWidth-1:0] shadow_keys  [chs_pkg::PoolNodes];
  int unsigned                  shadow_links [chs_pkg::PoolNodes];
  int unsigned                  shadow_free;
  int unsigned                  shadow_fresh;

  // Statuses still owed by the block, oldest first.
  chs_pkg::status_e pending_status [$];
  int      error_count = 0;
  int      cycle_count = 0;
  int      burst_left = 0;

  // Applies one transaction to the shadow table and returns its status.
  function automatic chs_pkg::status_e hash_set_apply(chs_pkg::op_e op,
                                                      logic [chs_pkg::KeyWidth-1:0] key);
    int unsigned n, b, prev, cur, steps, hit, hit_prev, node;
    n = shadow_buckets;
    if (n < chs_pkg::MinBuckets) n = chs_pkg::MinBuckets;
    if (n > chs_pkg::MaxBuckets) n = chs_pkg::MaxBuckets;
    b = key % n;
    // Walk the chain; the walk is bounded by the pool size.
    prev = chs_pkg::PoolNodes;
    cur = shadow_heads[b];
    steps = 0;
    hit = chs_pkg::PoolNodes;
    hit_prev = chs_pkg::PoolNodes;
    while (cur < chs_pkg::PoolNodes && steps < chs_pkg::PoolNodes &&
           hit == chs_pkg::PoolNodes) begin
      if (shadow_keys[cur] == key) begin
        hit = cur;
        hit_prev = prev;
      end else begin
        prev = cur;
        cur = shadow_links[cur];
        steps++;
      end
    end
    if (op == chs_pkg::OpInsert) begin
      if (hit != chs_pkg::PoolNodes) return chs_pkg::StPresent;
      // Released nodes are reused before fresh ones are taken.
      if (shadow_free < chs_pkg::PoolNodes) begin
        node = shadow_free;
        shadow_free = shadow_links[node];
      end else if (shadow_fresh < chs_pkg::PoolNodes) begin
        node = shadow_fresh;
        shadow_fresh++;
      end else begin
        return chs_pkg::StFull;
      end
      shadow_keys[node] = key;
      shadow_links[node] = shadow_heads[b];
      shadow_heads[b] = node;
      return chs_pkg::StOk;
    end else if (op == chs_pkg::OpDelete) begin
      if (hit == chs_pkg::PoolNodes) return chs_pkg::StAbsent;
      if (hit_prev == chs_pkg::PoolNodes) shadow_heads[b] = shadow_links[hit];
      else shadow_links[hit_prev] = shadow_links[hit];
      shadow_links[hit] = shadow_free;
      shadow_free = hit;
      return chs_pkg::StOk;
    end
    // Find, and the spare opcode, which behaves as a find.
    return (hit != chs_pkg::PoolNodes) ? chs_pkg::StOk : chs_pkg::StAbsent;
  endfunction

  // Issues one request and waits for the transaction to be accepted. The
  // start line stays high into the next request while a burst lasts, so it
  // only ever gets one nonblocking assignment per edge.
  task automatic issue_request(chs_pkg::op_e op, logic [chs_pkg::KeyWidth-1:0] key,
                               bit has_typed, chs_pkg::status_e typed);
    chs_pkg::status_e predicted;
    int gap;
    start <= 1'b1;
    opcode_i <= op;
    key_i <= key;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predicted = hash_set_apply(op, key);
    pending_status.push_back(has_typed ? typed : predicted);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      gap = $urandom_range(1, 12);
      repeat (gap) @(posedge clk_i);
      burst_left = $urandom_range(0, 20);
    end
  endtask

  // Drains the block, then writes the bucket count while it sits idle.
  task automatic write_bucket_count(logic [chs_pkg::CfgW-1:0] value);
    if (start) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    while (pending_status.size() != 0 || busy) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    shadow_buckets = value;
    cfg_we_i <= 1'b0;
    burst_left = 0;
  endtask

  // Result checker: each status strobe is matched with the oldest request.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_status.size() == 0) begin
        $display("%0t: unexpected status transaction, expected none, actual %0d",
                 $time, status_o);
        error_count++;
      end else begin
        if (status_o !== pending_status[0]) begin
          $display("%0t: status mismatch, expected %0d, actual %0d",
                   $time, pending_status[0], status_o);
          error_count++;
        end
        void'(pending_status.pop_front());
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > 5000000) begin
      $display("Verification failed");
      $finish;
    end
  end

  typedef struct {
    chs_pkg::op_e                 op;
    logic [chs_pkg::KeyWidth-1:0] key;
    bit                           has_typed;
    chs_pkg::status_e             typed;
  } request_row_t;

  // Directed rows with the reset bucket count of seven. Keys 0, 7, 14 and
  // 21 share one bucket, so deletes hit both the head and the tail of the chain.
  request_row_t directed [20] = '{
    '{chs_pkg::OpFind,   32'd0,          1'b1, chs_pkg::StAbsent},
    '{chs_pkg::OpInsert, 32'd0,          1'b1, chs_pkg::StOk},
    '{chs_pkg::OpInsert, 32'd0,          1'b1, chs_pkg::StPresent},
    '{chs_pkg::OpFind,   32'd0,          1'b1, chs_pkg::StOk},
    '{chs_pkg::OpInsert, 32'hFFFF_FFFF,  1'b1, chs_pkg::StOk},
    '{chs_pkg::OpFind,   32'hFFFF_FFFF,  1'b1, chs_pkg::StOk},
    '{chs_pkg::OpInsert, 32'd7,          1'b1, chs_pkg::StOk},
    '{chs_pkg::OpSpare,  32'd7,          1'b1, chs_pkg::StOk},
    '{chs_pkg::OpSpare,  32'd8,          1'b1, chs_pkg::StAbsent},
    '{chs_pkg::OpDelete, 32'd0,          1'b1, chs_pkg::StOk},
    '{chs_pkg::OpDelete, 32'd0,          1'b1, chs_pkg::StAbsent},
    '{chs_pkg::OpInsert, 32'd14,         1'b0, chs_pkg::StOk},
    '{chs_pkg::OpInsert, 32'd21,         1'b0, chs_pkg::StOk},
    '{chs_pkg::OpDelete, 32'd21,         1'b0, chs_pkg::StOk},
    '{chs_pkg::OpDelete, 32'd7,          1'b0, chs_pkg::StOk},
    '{chs_pkg::OpInsert, 32'd0,          1'b0, chs_pkg::StOk},
    '{chs_pkg::OpFind,   32'd14,         1'b0, chs_pkg::StOk},
    '{chs_pkg::OpDelete, 32'hFFFF_FFFF,  1'b1, chs_pkg::StOk},
    '{chs_pkg::OpFind,   32'hFFFF_FFFF,  1'b1, chs_pkg::StAbsent},
    '{chs_pkg::OpDelete, 32'h8000_0000,  1'b1, chs_pkg::StAbsent}
  };

  // Bucket counts visited by the random part, clamped extremes included.
  logic [chs_pkg::CfgW-1:0] bucket_plan [8] =
    '{9'd5, 9'd0, 9'd256, 9'd13, 9'd511, 9'd3, 9'd7, 9'd131};

  initial begin
    chs_pkg::op_e                 op;
    logic [chs_pkg::KeyWidth-1:0] key;
    int                           pick;

    shadow_buckets = chs_pkg::ResetBuckets;
    foreach (shadow_heads[i]) shadow_heads[i] = chs_pkg::PoolNodes;
    foreach (shadow_links[i]) shadow_links[i] = chs_pkg::PoolNodes;
    foreach (shadow_keys[i]) shadow_keys[i] = '0;
    shadow_free = chs_pkg::PoolNodes;
    shadow_fresh = 0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i])
      issue_request(directed[i].op, directed[i].key, directed[i].has_typed,
                    directed[i].typed);

    // Random part: mostly a small key space, so that finds hit, inserts
    // collide and deletes find their keys; some full-width keys as noise.
    // The mapping changes between phases while keys stay in the table.
    foreach (bucket_plan[p]) begin
      write_bucket_count(bucket_plan[p]);
      repeat (55) begin
        pick = $urandom_range(0, 9);
        op = (pick < 4) ? chs_pkg::OpInsert : (pick < 7) ? chs_pkg::OpDelete :
             (pick < 9) ? chs_pkg::OpFind : chs_pkg::OpSpare;
        if ($urandom_range(0, 7) == 0) key = $urandom;
        else key = $urandom_range(0, 95);
        issue_request(op, key, 1'b0, chs_pkg::StOk);
      end
    end

    // Add a run of fresh keys, free a few nodes and take them again
    // through the free list before fresh nodes are used once more.
    write_bucket_count(9'd256);
    for (int i = 0; i < 60; i++)
      issue_request(chs_pkg::OpInsert, 32'h4000_0000 + i, 1'b0, chs_pkg::StOk);
    for (int i = 0; i < 12; i++)
      issue_request(chs_pkg::OpDelete, 32'h4000_0000 + 3 * i, 1'b0, chs_pkg::StOk);
    for (int i = 0; i < 14; i++)
      issue_request(chs_pkg::OpInsert, 32'h5000_0000 + i, 1'b0, chs_pkg::StOk);
    for (int i = 0; i < 10; i++)
      issue_request(chs_pkg::op_e'($urandom_range(0, 3)),
                    32'h4000_0000 + $urandom_range(0, 40), 1'b0, chs_pkg::StOk);

    start <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
